// ----- rtl/tccs_pkg.sv -----
// Shared constants and controller/datapath interface types for the text console.
package tccs_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 8;
    localparam int INDEX_W  = 11;
    localparam int CELL_W   = 16;
    localparam int ROW_W    = 5;
    localparam int COLUMN_W = 7;

    localparam logic              CMD_PUT  = 1'b0;
    localparam logic              CMD_READ = 1'b1;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE     = 8'h0A;
    localparam logic [CHAR_W-1:0]  SPACE_CODE       = 8'h20;
    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h07;
    localparam logic [CELL_W-1:0]  BLANK_CELL       = 16'h0720;

    typedef struct packed {
        logic load_item;
        logic exec_put;
        logic rd_issue;
        logic rd_capture;
        logic clear_write;
        logic copy_step;
        logic fill_write;
        logic sweep_reset;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic item_read;
        logic exec_scroll;
        logic clear_last;
        logic copy_last;
        logic fill_last;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/text_console_cursor_scroll.sv -----
// Top level: character-cell text console with cursor, wrap and scroll.
// Input stalls until the previous item's result is loaded into the output registers, so one item
// is taken at a time; a scrolling put also runs a line copy and a bottom-line fill through one
// write port before its result is loaded.
// Reset: a clearing pass fills the screen with blanks in colour 0x07 while input stalls; the
// colour register is writable throughout.
module text_console_cursor_scroll #(
    parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [tccs_pkg::CHAR_W-1:0]   char_code,
    input  logic [tccs_pkg::INDEX_W-1:0]  read_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tccs_pkg::CELL_W-1:0]   read_data,
    output logic [tccs_pkg::ROW_W-1:0]    cursor_row,
    output logic [tccs_pkg::COLUMN_W-1:0] cursor_column,
    output logic                          scrolled,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tccs_pkg::COLOR_W-1:0]  text_color
);

    tccs_pkg::ctrl_cmd_t  cmd;
    tccs_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    tccs_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tccs_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .command       (command),
        .char_code     (char_code),
        .read_index    (read_index),
        .cfg_write     (cfg_valid && cfg_ready),
        .text_color    (text_color),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_data     (read_data),
        .cursor_row    (cursor_row),
        .cursor_column (cursor_column),
        .scrolled      (scrolled)
    );

endmodule

// ----- rtl/tccs_screen_ram.sv -----
// Screen cell memory: one write port, one registered read port.
module tccs_screen_ram #(
    parameter int DEPTH = tccs_pkg::COLUMNS_DEF * tccs_pkg::ROWS_DEF,
    parameter int AW    = $clog2(tccs_pkg::COLUMNS_DEF * tccs_pkg::ROWS_DEF)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [tccs_pkg::CELL_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [tccs_pkg::CELL_W-1:0] rdata
);

    logic [tccs_pkg::CELL_W-1:0] cells_reg [DEPTH];
    logic [tccs_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cells_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= cells_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tccs_datapath.sv -----
// Datapath: cursor, colour, item and result registers, sweep counter and screen memory.
module tccs_datapath #(
    parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tccs_pkg::ctrl_cmd_t           cmd,
    output tccs_pkg::dp_status_t          status,
    input  logic                          command,
    input  logic [tccs_pkg::CHAR_W-1:0]   char_code,
    input  logic [tccs_pkg::INDEX_W-1:0]  read_index,
    input  logic                          cfg_write,
    input  logic [tccs_pkg::COLOR_W-1:0]  text_color,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tccs_pkg::CELL_W-1:0]   read_data,
    output logic [tccs_pkg::ROW_W-1:0]    cursor_row,
    output logic [tccs_pkg::COLUMN_W-1:0] cursor_column,
    output logic                          scrolled
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW = $clog2(CELL_COUNT);
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);

    localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
    localparam logic [AW-1:0] CLEAR_LAST = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0] COPY_LAST  = AW'(CELL_COUNT - COLUMNS);
    localparam logic [AW-1:0] FILL_BASE  = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0] FILL_LAST  = AW'(COLUMNS - 1);
    localparam logic [AW-1:0] ADDR_ONE   = AW'(1);
    localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
    localparam logic [RW-1:0] ROW_ONE    = RW'(1);
    localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
    localparam logic [CW-1:0] COL_ONE    = CW'(1);
    localparam logic [15:0]   CELL_LIMIT = 16'(CELL_COUNT);

    logic [RW-1:0]                 row_reg, row_next;
    logic [CW-1:0]                 col_reg, col_next;
    logic [tccs_pkg::COLOR_W-1:0]  color_reg;
    logic [AW-1:0]                 sweep_reg, sweep_next;
    logic                          item_cmd_reg;
    logic [tccs_pkg::CHAR_W-1:0]   item_char_reg;
    logic [tccs_pkg::INDEX_W-1:0]  item_idx_reg;
    logic                          item_in_range_reg;
    logic [tccs_pkg::CELL_W-1:0]   res_data_reg;
    logic                          res_scrolled_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [tccs_pkg::CELL_W-1:0]   out_data_reg;
    logic [tccs_pkg::ROW_W-1:0]    out_row_reg;
    logic [tccs_pkg::COLUMN_W-1:0] out_col_reg;
    logic                          out_scrolled_reg;

    logic                          is_newline;
    logic                          line_adv;
    logic                          at_bottom;
    logic                          item_read;
    logic                          sweep_first;
    logic                          sweep_copy_end;
    logic [AW+tccs_pkg::INDEX_W-1:0]       idx_ext;
    logic [AW-1:0]                         idx_addr;
    logic [AW-1:0]                         cursor_addr;
    logic [RW+tccs_pkg::ROW_W-1:0]         row_ext;
    logic [CW+tccs_pkg::COLUMN_W-1:0]      col_ext;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [tccs_pkg::CELL_W-1:0]   ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [tccs_pkg::CELL_W-1:0]   ram_rdata;

    assign item_read      = (item_cmd_reg == tccs_pkg::CMD_READ);
    assign is_newline     = (item_char_reg == tccs_pkg::NEWLINE_CODE);
    assign line_adv       = is_newline || (col_reg == LAST_COL);
    assign at_bottom      = (row_reg == LAST_ROW);
    assign sweep_first    = (sweep_reg == '0);
    assign sweep_copy_end = (sweep_reg == COPY_LAST);
    assign idx_ext        = {{AW{1'b0}}, item_idx_reg};
    assign idx_addr       = idx_ext[AW-1:0];
    assign cursor_addr    = AW'(row_reg) * COLS_A + AW'(col_reg);

    assign status.item_read   = item_read;
    assign status.exec_scroll = !item_read && line_adv && at_bottom;
    assign status.clear_last  = (sweep_reg == CLEAR_LAST);
    assign status.copy_last   = sweep_copy_end;
    assign status.fill_last   = (sweep_reg == FILL_LAST);
    assign status.out_free    = !out_valid_reg || !out_stall;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cmd.exec_put)
        begin
            if (line_adv)
            begin
                col_next = '0;
                if (!at_bottom)
                begin
                    row_next = row_reg + ROW_ONE;
                end
            end
            else
            begin
                col_next = col_reg + COL_ONE;
            end
        end
    end

    always_comb
    begin
        sweep_next = sweep_reg;
        priority if (cmd.sweep_reset)
        begin
            sweep_next = '0;
        end
        else if (cmd.clear_write || cmd.copy_step || cmd.fill_write)
        begin
            sweep_next = sweep_reg + ADDR_ONE;
        end
        else
        begin
            sweep_next = sweep_reg;
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = sweep_reg;
        ram_wdata = tccs_pkg::BLANK_CELL;
        if (cmd.clear_write)
        begin
            ram_we    = 1'b1;
            ram_waddr = sweep_reg;
            ram_wdata = tccs_pkg::BLANK_CELL;
        end
        else if (cmd.fill_write)
        begin
            ram_we    = 1'b1;
            ram_waddr = FILL_BASE + sweep_reg;
            ram_wdata = {color_reg, tccs_pkg::SPACE_CODE};
        end
        else if (cmd.copy_step)
        begin
            ram_we    = !sweep_first;
            ram_waddr = sweep_reg - ADDR_ONE;
            ram_wdata = ram_rdata;
        end
        else if (cmd.exec_put)
        begin
            ram_we    = !is_newline;
            ram_waddr = cursor_addr;
            ram_wdata = {color_reg, item_char_reg};
        end
    end

    assign ram_re    = cmd.rd_issue || (cmd.copy_step && !sweep_copy_end);
    assign ram_raddr = cmd.rd_issue ? idx_addr : (sweep_reg + COLS_A);

    tccs_screen_ram #(
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid_next = cmd.load_out ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            color_reg     <= tccs_pkg::TEXT_COLOR_RESET;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                color_reg <= text_color;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_cmd_reg      <= command;
            item_char_reg     <= char_code;
            item_idx_reg      <= read_index;
            item_in_range_reg <= ({5'b0, read_index} < CELL_LIMIT);
        end
        if (cmd.exec_put)
        begin
            res_data_reg     <= '0;
            res_scrolled_reg <= status.exec_scroll;
        end
        else if (cmd.rd_issue)
        begin
            res_scrolled_reg <= 1'b0;
        end
        else if (cmd.rd_capture)
        begin
            res_data_reg <= item_in_range_reg ? ram_rdata : '0;
        end
        if (cmd.load_out)
        begin
            out_data_reg     <= res_data_reg;
            out_row_reg      <= row_ext[tccs_pkg::ROW_W-1:0];
            out_col_reg      <= col_ext[tccs_pkg::COLUMN_W-1:0];
            out_scrolled_reg <= res_scrolled_reg;
        end
    end

    assign row_ext = {{tccs_pkg::ROW_W{1'b0}}, row_reg};
    assign col_ext = {{tccs_pkg::COLUMN_W{1'b0}}, col_reg};

    assign out_valid     = out_valid_reg;
    assign read_data     = out_data_reg;
    assign cursor_row    = out_row_reg;
    assign cursor_column = out_col_reg;
    assign scrolled      = out_scrolled_reg;

endmodule

// ----- rtl/tccs_controller.sv -----
// Controller state machine: clearing pass, item execution, scroll copy and fill, result hand-off.
module tccs_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  tccs_pkg::dp_status_t status,
    output tccs_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_EXEC  = 7'b0000100,
        ST_RDATA = 7'b0001000,
        ST_COPY  = 7'b0010000,
        ST_FILL  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                if (status.clear_last)
                begin
                    cmd.sweep_reset = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.item_read)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_RDATA;
                end
                else
                begin
                    cmd.exec_put = 1'b1;
                    if (status.exec_scroll)
                    begin
                        cmd.sweep_reset = 1'b1;
                        state_next      = ST_COPY;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RDATA:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = ST_DONE;
            end
            ST_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (status.copy_last)
                begin
                    cmd.sweep_reset = 1'b1;
                    state_next      = ST_FILL;
                end
            end
            ST_FILL:
            begin
                cmd.fill_write = 1'b1;
                if (status.fill_last)
                begin
                    cmd.sweep_reset = 1'b1;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

// ----- tb/text_console_cursor_scroll_tb.sv -----
// Self-checking testbench for the text console: cursor, wrap, scroll and cell reads.
module text_console_cursor_scroll_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tccs_pkg::*;

    localparam int COLUMNS    = COLUMNS_DEF;
    localparam int ROWS       = ROWS_DEF;
    localparam int CELLS      = COLUMNS * ROWS;
    localparam int PHASES     = 5;
    localparam int PHASE_LEN  = 400;
    localparam int TABLE_LEN  = 24;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [CELL_W-1:0]   data;
        logic [ROW_W-1:0]    row;
        logic [COLUMN_W-1:0] column;
        logic                scrl;
    } console_result_t;

    typedef struct packed {
        logic                cmd;
        logic [CHAR_W-1:0]   ch;
        logic [INDEX_W-1:0]  idx;
        logic                known;
        console_result_t     res;
    } directed_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                command;
    logic [CHAR_W-1:0]   char_code;
    logic [INDEX_W-1:0]  read_index;
    logic                out_valid;
    logic                out_stall;
    logic [CELL_W-1:0]   read_data;
    logic [ROW_W-1:0]    cursor_row;
    logic [COLUMN_W-1:0] cursor_column;
    logic                scrolled;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [COLOR_W-1:0]  text_color;

    logic [CELL_W-1:0]   screen_mirror [CELLS];
    int unsigned         row_mirror;
    int unsigned         column_mirror;
    logic [COLOR_W-1:0]  color_mirror;

    console_result_t     awaited_results [$];
    int                  mismatches;
    longint              cycle_count;
    int                  gap_pct;
    int                  stall_pct;
    int                  stall_left;

    directed_row_t directed_tbl [TABLE_LEN] = '{
        '{CMD_READ, 8'h00, 11'd0,    1'b1, '{BLANK_CELL, 5'd0, 7'd0, 1'b0}},
        '{CMD_READ, 8'h00, 11'd1999, 1'b1, '{BLANK_CELL, 5'd0, 7'd0, 1'b0}},
        '{CMD_READ, 8'hFF, 11'd2047, 1'b1, '{16'h0000,   5'd0, 7'd0, 1'b0}},
        '{CMD_READ, 8'h00, 11'd2000, 1'b1, '{16'h0000,   5'd0, 7'd0, 1'b0}},
        '{CMD_PUT,  8'h41, 11'd0,    1'b1, '{16'h0000,   5'd0, 7'd1, 1'b0}},
        '{CMD_PUT,  8'h00, 11'd0,    1'b1, '{16'h0000,   5'd0, 7'd2, 1'b0}},
        '{CMD_PUT,  8'hFF, 11'd0,    1'b1, '{16'h0000,   5'd0, 7'd3, 1'b0}},
        '{CMD_PUT,  8'h09, 11'd0,    1'b1, '{16'h0000,   5'd0, 7'd4, 1'b0}},
        '{CMD_PUT,  8'h0D, 11'd0,    1'b1, '{16'h0000,   5'd0, 7'd5, 1'b0}},
        '{CMD_READ, 8'h00, 11'd0,    1'b1, '{16'h1E41,   5'd0, 7'd5, 1'b0}},
        '{CMD_READ, 8'h00, 11'd2,    1'b1, '{16'h1EFF,   5'd0, 7'd5, 1'b0}},
        '{CMD_PUT,  NEWLINE_CODE, 11'd0, 1'b1, '{16'h0000, 5'd1, 7'd0, 1'b0}},
        '{CMD_PUT,  8'h80, 11'd0,    1'b1, '{16'h0000,   5'd1, 7'd1, 1'b0}},
        '{CMD_PUT,  8'h7F, 11'h7FF,  1'b0, '0},
        '{CMD_READ, 8'hFF, 11'd80,   1'b1, '{16'h1E80,   5'd1, 7'd2, 1'b0}},
        '{CMD_PUT,  NEWLINE_CODE, 11'd0, 1'b0, '0},
        '{CMD_PUT,  NEWLINE_CODE, 11'd0, 1'b0, '0},
        '{CMD_PUT,  8'h55, 11'h555,  1'b0, '0},
        '{CMD_PUT,  8'hAA, 11'h2AA,  1'b0, '0},
        '{CMD_READ, 8'h00, 11'd1024, 1'b0, '0},
        '{CMD_READ, 8'h55, 11'h555,  1'b0, '0},
        '{CMD_READ, 8'hAA, 11'h2AA,  1'b0, '0},
        '{CMD_READ, 8'h00, 11'd1,    1'b1, '{16'h1E00,   5'd3, 7'd2, 1'b0}},
        '{CMD_READ, 8'h00, 11'd1999, 1'b1, '{BLANK_CELL, 5'd3, 7'd2, 1'b0}}
    };

    int phase_gap   [PHASES] = '{25, 0, 40, 10, 0};
    int phase_stall [PHASES] = '{25, 40, 0, 10, 0};

    text_console_cursor_scroll dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .char_code     (char_code),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_data     (read_data),
        .cursor_row    (cursor_row),
        .cursor_column (cursor_column),
        .scrolled      (scrolled),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .text_color    (text_color)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic console_newline();
        int unsigned i;
        logic        did_scroll;
        did_scroll = 1'b0;
        row_mirror++;
        if (row_mirror >= ROWS)
        begin
            for (i = COLUMNS; i < CELLS; i++)
                screen_mirror[i - COLUMNS] = screen_mirror[i];
            for (i = 0; i < COLUMNS; i++)
                screen_mirror[(ROWS - 1) * COLUMNS + i] = {color_mirror, SPACE_CODE};
            row_mirror = ROWS - 1;
            did_scroll = 1'b1;
        end
        column_mirror = 0;
        return did_scroll;
    endfunction

    function automatic console_result_t console_step(input logic cmd,
                                                     input logic [CHAR_W-1:0] ch,
                                                     input logic [INDEX_W-1:0] idx);
        console_result_t r;
        r = '0;
        if (cmd == CMD_READ)
        begin
            if (idx < CELLS)
                r.data = screen_mirror[idx];
        end
        else if (ch == NEWLINE_CODE)
        begin
            r.scrl = console_newline();
        end
        else
        begin
            screen_mirror[row_mirror * COLUMNS + column_mirror] = {color_mirror, ch};
            column_mirror++;
            if (column_mirror >= COLUMNS)
                r.scrl = console_newline();
        end
        r.row    = row_mirror[ROW_W-1:0];
        r.column = column_mirror[COLUMN_W-1:0];
        return r;
    endfunction

    task automatic issue_item(input logic cmd, input logic [CHAR_W-1:0] ch,
                              input logic [INDEX_W-1:0] idx, input logic known,
                              input console_result_t known_res);
        console_result_t predicted;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13) - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        command    <= cmd;
        char_code  <= ch;
        read_index <= idx;
        do @(posedge clk); while (in_stall);
        predicted = console_step(cmd, ch, idx);
        awaited_results.push_back(known ? known_res : predicted);
    endtask

    task automatic write_color(input logic [COLOR_W-1:0] c);
        @(negedge clk);
        in_valid   <= 1'b0;
        cfg_valid  <= 1'b1;
        text_color <= c;
        do @(posedge clk); while (!cfg_ready);
        color_mirror = c;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if ($urandom_range(0, 99) < stall_pct)
            stall_left = $urandom_range(1, 13);
        out_stall <= (stall_left > 0);
    end

    always @(posedge clk)
    begin
        console_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected transaction: read_data %h row %0d column %0d scrolled %b",
                       read_data, cursor_row, cursor_column, scrolled);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (read_data !== want.data)
                begin
                    $error("read_data: expected %h, actual %h", want.data, read_data);
                    mismatches++;
                end
                if (cursor_row !== want.row)
                begin
                    $error("cursor_row: expected %0d, actual %0d", want.row, cursor_row);
                    mismatches++;
                end
                if (cursor_column !== want.column)
                begin
                    $error("cursor_column: expected %0d, actual %0d", want.column,
                           cursor_column);
                    mismatches++;
                end
                if (scrolled !== want.scrl)
                begin
                    $error("scrolled: expected %b, actual %b", want.scrl, scrolled);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        logic                cmd;
        logic [CHAR_W-1:0]   ch;
        logic [INDEX_W-1:0]  idx;
        int unsigned         near_row;
        logic [COLOR_W-1:0]  phase_color;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        command     = CMD_PUT;
        char_code   = '0;
        read_index  = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        text_color  = '0;
        mismatches  = 0;
        cycle_count = 0;
        stall_left  = 0;
        gap_pct     = 20;
        stall_pct   = 20;
        for (int i = 0; i < CELLS; i++)
            screen_mirror[i] = BLANK_CELL;
        row_mirror    = 0;
        column_mirror = 0;
        color_mirror  = TEXT_COLOR_RESET;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_color(8'h1E);
        for (int i = 0; i < TABLE_LEN; i++)
            issue_item(directed_tbl[i].cmd, directed_tbl[i].ch, directed_tbl[i].idx,
                       directed_tbl[i].known, directed_tbl[i].res);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: phase_color = 8'h00;
                1: phase_color = 8'hFF;
                4: phase_color = 8'h5A;
                default: phase_color = 8'($urandom_range(0, 255));
            endcase
            drain_results();
            write_color(phase_color);
            gap_pct   = phase_gap[p];
            stall_pct = phase_stall[p];
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                ch  = 8'($urandom_range(0, 255));
                idx = 11'($urandom_range(0, 2047));
                case ($urandom_range(0, 99)) inside
                    [0:59]:
                        cmd = CMD_PUT;
                    [60:65]:
                    begin
                        cmd = CMD_PUT;
                        ch  = NEWLINE_CODE;
                    end
                    default:
                    begin
                        cmd = CMD_READ;
                        if ($urandom_range(0, 1) == 1)
                        begin
                            near_row = row_mirror;
                            if ($urandom_range(0, 1) == 1 && near_row > 0)
                                near_row--;
                            idx = 11'(near_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
                        end
                    end
                endcase
                issue_item(cmd, ch, idx, 1'b0, '0);
                if ($urandom_range(0, 299) == 0)
                    drain_results();
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
